/* sv/humidity_sensor_frame_decoder_defines.svh */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_defines
// Assertion macros shared by the frame decoder RTL. They expect clk and rst_n
// in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_DEFINES_SVH

// property must hold at every clock outside reset
`define HSFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define HSFD_ASSERT_NEVER(label, expr, msg) \
    `HSFD_ASSERT(label, !(expr), msg)

`endif

/* sv/hsfd_pkg.sv */
// ----------------------------------------------------------------------------
// hsfd_pkg
// Types and constants of the sensor frame decoder: CRC-16/MODBUS constants,
// frame byte positions, reset values and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

    localparam int IDX_W = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [6:0]  MAG_MASK = 7'h7F;
    localparam logic [7:0]  SIGN_BIT = 8'h80;

    // byte positions inside the 8-byte response
    localparam logic [IDX_W-1:0] IDX_FIRST  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_HUM_HI = 3'd2;
    localparam logic [IDX_W-1:0] IDX_HUM_LO = 3'd3;
    localparam logic [IDX_W-1:0] IDX_TMP_HI = 3'd4;
    localparam logic [IDX_W-1:0] IDX_TMP_LO = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CRC_LO = 3'd6;
    localparam logic [IDX_W-1:0] IDX_CRC_HI = 3'd7;

    localparam logic [15:0] GOOD_HUM_RESET = 16'd550;
    localparam logic [15:0] GOOD_TMP_RESET = 16'd270;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [15:0]        hum;
        logic signed [15:0] temp;
    } res_t;

    // reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // sign-magnitude tenths to two's complement
    function automatic logic signed [15:0] sm_to_tc(input logic [15:0] raw);
        logic [15:0] mag;
        mag = {1'b0, raw[14:8] & MAG_MASK, raw[7:0]};
        return (raw[15:8] & SIGN_BIT) != 8'h00 ? $signed(16'h0000 - mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

/* sv/hsfd_frame.sv */
// ----------------------------------------------------------------------------
// hsfd_frame
// Frame state: byte position, running CRC, captured raw fields and the last
// good values. Steps once per byte; result is combinational on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "humidity_sensor_frame_decoder_defines.svh"

module hsfd_frame
    import hsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_start,
    output res_t            res
);

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      hum_raw_reg, hum_raw_next;
    logic [15:0]      tmp_raw_reg, tmp_raw_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [15:0]      good_hum_reg, good_hum_next;
    logic [15:0]      good_tmp_reg, good_tmp_next;

    logic [IDX_W-1:0] idx;
    logic [15:0]      crc_base;
    logic [15:0]      crc_upd;
    logic             crc_match;
    logic signed [15:0] tmp_conv;

    assign idx       = frame_start ? IDX_FIRST : byte_index_reg;
    assign crc_base  = (idx == IDX_FIRST) ? CRC_INIT : crc_reg;
    assign crc_upd   = crc16_byte(crc_base, rx_byte);
    assign crc_match = ({rx_byte, crc_lo_reg} == crc_reg);
    assign tmp_conv  = sm_to_tc(tmp_raw_reg);

    assign res.valid = (idx == IDX_CRC_HI);
    assign res.ok    = crc_match;
    assign res.hum   = crc_match ? hum_raw_reg : good_hum_reg;
    assign res.temp  = crc_match ? tmp_conv : $signed(good_tmp_reg);

    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        hum_raw_next    = hum_raw_reg;
        tmp_raw_next    = tmp_raw_reg;
        crc_lo_next     = crc_lo_reg;
        good_hum_next   = good_hum_reg;
        good_tmp_next   = good_tmp_reg;
        if (step)
        begin
            byte_index_next = idx + 3'd1;
            if (idx < IDX_CRC_LO)
            begin
                crc_next = crc_upd;
            end
            unique case (idx)
                IDX_HUM_HI: hum_raw_next = {rx_byte, hum_raw_reg[7:0]};
                IDX_HUM_LO: hum_raw_next = {hum_raw_reg[15:8], rx_byte};
                IDX_TMP_HI: tmp_raw_next = {rx_byte, tmp_raw_reg[7:0]};
                IDX_TMP_LO: tmp_raw_next = {tmp_raw_reg[15:8], rx_byte};
                IDX_CRC_LO: crc_lo_next  = rx_byte;
                IDX_CRC_HI:
                begin
                    if (crc_match)
                    begin
                        good_hum_next = hum_raw_reg;
                        good_tmp_next = tmp_conv;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= IDX_FIRST;
            crc_reg        <= CRC_INIT;
            hum_raw_reg    <= '0;
            tmp_raw_reg    <= '0;
            crc_lo_reg     <= '0;
            good_hum_reg   <= GOOD_HUM_RESET;
            good_tmp_reg   <= GOOD_TMP_RESET;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            hum_raw_reg    <= hum_raw_next;
            tmp_raw_reg    <= tmp_raw_next;
            crc_lo_reg     <= crc_lo_next;
            good_hum_reg   <= good_hum_next;
            good_tmp_reg   <= good_tmp_next;
        end
    end

    `HSFD_ASSERT(a_start_restarts, (step && frame_start) |=> (byte_index_reg == IDX_FIRST + 3'd1), "frame start did not restart byte count")
    `HSFD_ASSERT(a_good_follows_ok, (step && res.valid && res.ok) |=> (good_hum_reg == $past(hum_raw_reg)), "good humidity not updated on CRC match")

endmodule

`default_nettype wire

/* sv/hsfd_out_buf.sv */
// ----------------------------------------------------------------------------
// hsfd_out_buf
// Two-entry result buffer. Decouples the output stall from the byte pipe so
// a waiting result blocks intake only once both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "humidity_sensor_frame_decoder_defines.svh"

module hsfd_out_buf
    import hsfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      full,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      head
);

    res_t       data_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign head      = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HSFD_ASSERT_NEVER(a_no_overflow, push && full, "result pushed into full buffer")
    `HSFD_ASSERT(a_count_track, (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1), "buffer count lost a push")

endmodule

`default_nettype wire

/* sv/humidity_sensor_frame_decoder.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Checks and decodes the 8-byte sensor read response (CRC-16/MODBUS).
// ----------------------------------------------------------------------------
// Input channel: one response byte per beat (rx_byte), frame_start marks
// byte 0 and restarts a partial frame; without it bytes count 0..7 and wrap.
// Output channel: one beat per eighth byte, carrying frame_ok and the last
// good humidity / temperature (tenths, temperature signed). Bad frames repeat the old values.
// Throughput: one byte per cycle while in_stall is low; the byte-wide CRC step
// is combinational logic between the input register and the result buffer.
// Result path: the result of byte 7 passes the input register, then the result
// buffer, before out_valid; a full buffer holds it in the input register.
// Stall: results wait in a two-entry buffer. in_stall rises only when a
// last byte sits in the input register and the buffer is full.
// Reset: byte count to 0, CRC to 0xFFFF, last good values to 55.0 %RH and
// 27.0 degrees, buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_decoder
    import hsfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             frame_ok,
    output logic [15:0]      humidity_tenths,
    output logic signed [15:0] temperature_tenths
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       in_acc;
    logic       s1_adv;
    logic       buf_full;
    res_t       res;
    res_t       head;

    assign in_acc   = in_valid && !in_stall;
    assign s1_adv   = s1_valid_reg && !(res.valid && buf_full);
    assign in_stall = s1_valid_reg && res.valid && buf_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
    end

    hsfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .rx_byte     (s1_byte_reg),
        .frame_start (s1_start_reg),
        .res         (res)
    );

    hsfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_adv && res.valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign frame_ok           = head.ok;
    assign humidity_tenths    = head.hum;
    assign temperature_tenths = head.temp;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor response decoder. Bytes go in as
// frames: some are good, some have a broken CRC, some are cut short and some
// are line noise. A bit-level model tracks the frame position, the CRC and the
// last good readings, and each result beat is checked against it. Both the
// sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module tb
    import hsfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               ok;
        logic [15:0]        hum;
        logic signed [15:0] temp;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               frame_start;
    logic               out_valid;
    logic               out_stall;
    logic               frame_ok;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;

    // decoder model state
    logic [IDX_W-1:0] frame_pos   = IDX_FIRST;
    logic [15:0]      crc_acc     = CRC_INIT;
    logic [15:0]      hum_bytes   = '0;
    logic [15:0]      tmp_bytes   = '0;
    logic [7:0]       crc_lo_byte = '0;
    logic [15:0]      last_hum    = GOOD_HUM_RESET;
    logic [15:0]      last_temp   = GOOD_TMP_RESET;

    reading_t pending_readings[$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int burst_left     = 0;

    // receiver stall pattern
    int   stall_mode  = 0;
    int   stall_phase = 0;
    int   stall_run   = 0;
    logic stall_hold  = 1'b0;

    humidity_sensor_frame_decoder dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_ok           (frame_ok),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                      input logic [7:0]  data);
        logic [15:0] c;
        c = acc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // advance the model by one accepted byte; queue a reading on the last byte
    task automatic predict_reading(input logic [7:0] b, input logic st);
        reading_t    r;
        logic [15:0] mag;
        if (st)
            frame_pos = IDX_FIRST;
        if (frame_pos == IDX_FIRST)
            crc_acc = CRC_INIT;
        if (frame_pos < IDX_CRC_LO)
        begin
            crc_acc = crc16_modbus_step(crc_acc, b);
            case (frame_pos)
                IDX_HUM_HI: hum_bytes[15:8] = b;
                IDX_HUM_LO: hum_bytes[7:0]  = b;
                IDX_TMP_HI: tmp_bytes[15:8] = b;
                IDX_TMP_LO: tmp_bytes[7:0]  = b;
                default: ;
            endcase
        end
        else if (frame_pos == IDX_CRC_LO)
        begin
            crc_lo_byte = b;
        end
        else
        begin
            r.ok = ({b, crc_lo_byte} == crc_acc);
            if (r.ok)
            begin
                // sign-magnitude: negative zero ends up as plain zero
                mag = {1'b0, tmp_bytes[14:8] & MAG_MASK, tmp_bytes[7:0]};
                last_hum = hum_bytes;
                if ((tmp_bytes[15:8] & SIGN_BIT) != 8'h00)
                    last_temp = 16'h0000 - mag;
                else
                    last_temp = mag;
            end
            r.hum  = last_hum;
            r.temp = $signed(last_temp);
            pending_readings.push_back(r);
        end
        frame_pos = frame_pos + 1'b1;
    endtask

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= st;
        do
            @(posedge clk);
        while (in_stall);
        predict_reading(b, st);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [15:0] hum, input logic [15:0] tmp,
                              input logic first_start, input logic corrupt);
        logic [7:0]  fb [8];
        logic [15:0] crc;
        int          k;
        fb[0] = 8'($urandom);
        fb[1] = 8'($urandom);
        fb[2] = hum[15:8];
        fb[3] = hum[7:0];
        fb[4] = tmp[15:8];
        fb[5] = tmp[7:0];
        crc = CRC_INIT;
        for (k = 0; k < 6; k++)
            crc = crc16_modbus_step(crc, fb[k]);
        fb[6] = crc[7:0];
        fb[7] = crc[15:8];
        if (corrupt)
        begin
            k = $urandom_range(0, 7);
            fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (k = 0; k < 8; k++)
            send_byte(fb[k], (k == 0) ? first_start : 1'b0);
    endtask

    // first frame after reset, no frame_start, CRC high byte inverted
    task automatic test_reset_values();
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++)
        begin
            crc = crc16_modbus_step(crc, 8'hFF);
            send_byte(8'hFF, 1'b0);
        end
        send_byte(crc[7:0], 1'b0);
        send_byte(~crc[15:8], 1'b0);
    endtask

    task automatic test_negative_zero();
        send_frame(16'h0000, 16'h8000, 1'b1, 1'b0);
    endtask

    // partial frame dropped by a new frame_start, then full-scale values
    task automatic test_restart_mid_frame();
        send_byte(8'h00, 1'b1);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int          kind;
        int          n;
        logic [15:0] hum;
        logic [15:0] tmp;
        logic        st;
        while (bytes_sent < 650)
        begin
            kind = $urandom_range(0, 19);
            case ($urandom_range(0, 7))
                0: hum = 16'h0000;
                1: hum = 16'hFFFF;
                default: hum = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: tmp = 16'h8000;
                1: tmp = 16'h7FFF;
                2: tmp = 16'hFFFF;
                3: tmp = 16'h0000;
                default: tmp = 16'($urandom);
            endcase
            // aligned frames may rely on the index wrapping instead of frame_start
            st = (frame_pos != IDX_FIRST) || ($urandom_range(0, 2) != 0);
            if (kind < 13)
                send_frame(hum, tmp, st, 1'b0);
            else if (kind < 16)
                send_frame(hum, tmp, st, 1'b1);
            else if (kind < 18)
            begin
                n = $urandom_range(1, 7);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom), k == 0);
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat ok=%0b hum=%0d temp=%0d",
                                        frame_ok, humidity_tenths, temperature_tenths));
            end
            else
            begin
                want = pending_readings.pop_front();
                if (frame_ok !== want.ok)
                    note_mismatch($sformatf("frame_ok exp %0b got %0b",
                                            want.ok, frame_ok));
                if (humidity_tenths !== want.hum)
                    note_mismatch($sformatf("humidity_tenths exp %0d got %0d",
                                            want.hum, humidity_tenths));
                if (temperature_tenths !== want.temp)
                    note_mismatch($sformatf("temperature_tenths exp %0d got %0d",
                                            want.temp, temperature_tenths));
            end
        end
    end

    // receiver: free-flowing, scattered stalls, or long on/off runs
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_phase = $urandom_range(40, 200);
        end
        else
        begin
            stall_phase--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_run  = $urandom_range(1, 12);
                    stall_hold = ~stall_hold;
                end
                stall_run--;
                out_stall <= stall_hold;
            end
        endcase
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        frame_start = 1'b0;
        out_stall   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_negative_zero();
        test_restart_mid_frame();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/hsfd_pkg.sv
sv/hsfd_frame.sv
sv/hsfd_out_buf.sv
sv/humidity_sensor_frame_decoder.sv
tb/sv/tb.sv
